>>> sv/ebf_pkg.sv
// ----------------------------------------------------------------------------
// ebf_pkg
// Shared types and constants for the eased brightness fader.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ebf_pkg;

  // Field widths
  localparam int LVL_W  = 10;   // brightness level
  localparam int REQ_W  = 12;   // requested level on the input
  localparam int STEP_W = 6;    // curve step index
  localparam int CRV_W  = 18;   // curve entry, signed Q2.16
  localparam int FRAC_W = 16;   // fraction bits of a curve entry

  // Brightness ceiling
  localparam logic [LVL_W-1:0] MAX_LEVEL = 10'd512;

  // Command codes
  typedef enum logic [2:0] {
    FUNC_SET  = 3'd0,
    FUNC_ON   = 3'd1,
    FUNC_OFF  = 3'd2,
    FUNC_TICK = 3'd3,
    FUNC_LOAD = 3'd4
  } ebf_func_t;

endpackage

`default_nettype wire

>>> sv/eased_brightness_fader.sv
// ----------------------------------------------------------------------------
// eased_brightness_fader
// Backlight fade engine: level commands and ticks step an eased fade along
// a curve held in on-chip memory.
// Flow: the curve entry is read on the input transfer into a registered
// read port beside stage 1, then the update enters the output register.
// Throughput: one item per cycle while the output is not stalled, set by the
// registered curve memory read and the one-stage multiply-add update.
// Reset (synchronous, active low) clears all levels, direction and index;
// the curve memory is not cleared and must be loaded before a fade runs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module eased_brightness_fader
  import ebf_pkg::*;
#(
  parameter int CURVE_STEPS = 41
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  // Command channel
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [2:0]               in_func,
  input  wire logic                     in_fade,
  input  wire logic [REQ_W-1:0]         in_level,
  input  wire logic [STEP_W-1:0]        in_curve_index,
  input  wire logic signed [CRV_W-1:0]  in_curve_value,
  // Result channel
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic [LVL_W-1:0]              out_drive_level,
  output logic                          out_drive_written,
  output logic                          out_fading
);

  localparam int MEM_AW = (CURVE_STEPS > 1) ? $clog2(CURVE_STEPS) : 1;
  localparam logic [STEP_W-1:0] STEP_LAST  = STEP_W'(CURVE_STEPS - 1);
  localparam logic [STEP_W:0]   STEP_COUNT = (STEP_W + 1)'(CURVE_STEPS);

  // Curve memory and its registered read port
  logic signed [CRV_W-1:0] curve_mem [CURVE_STEPS];
  logic signed [CRV_W-1:0] curve_rd_r;

  // Stage 1: accepted command waiting for its curve entry
  logic              s1_valid_r;
  logic [2:0]        s1_func_r;
  logic              s1_fade_r;
  logic [REQ_W-1:0]  s1_level_r;

  // Fader state
  logic [LVL_W-1:0]  start_r,   start_nxt;
  logic [LVL_W-1:0]  target_r,  target_nxt;
  logic [LVL_W-1:0]  current_r, current_nxt;
  logic [LVL_W-1:0]  remem_r,   remem_nxt;
  logic              down_r,    down_nxt;
  logic [STEP_W-1:0] step_r,    step_nxt;
  logic              written_nxt;

  // Output register
  logic              out_valid_r;
  logic [LVL_W-1:0]  out_level_r;
  logic              out_written_r;
  logic              out_fading_r;

  logic              in_fire;
  logic              s1_fire;
  logic [STEP_W-1:0] rd_addr;

  // Datapath signals for one fade step
  logic [LVL_W-1:0]            req_sat;
  logic signed [LVL_W:0]       diff;
  logic [LVL_W-1:0]            base;
  logic signed [LVL_W+CRV_W:0] prod;
  logic signed [LVL_W+CRV_W:0] prod_adj;
  logic signed [LVL_W+2:0]     ease;
  logic signed [LVL_W+3:0]     sum;
  logic [LVL_W-1:0]            stepped;

  // Handshake: stage 1 moves on when the output register is free or drains
  assign s1_fire  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_fire;
  assign in_fire  = in_valid && in_ready;

  // Read at the index left by the item finishing in stage 1 this cycle
  assign rd_addr = s1_fire ? step_nxt : step_r;

  // Curve write on transfer; entries past the curve are dropped
  always_ff @(posedge clk) begin
    if (in_fire && in_func == FUNC_LOAD && {1'b0, in_curve_index} < STEP_COUNT) begin
      curve_mem[in_curve_index[MEM_AW-1:0]] <= in_curve_value;
    end
  end

  // Curve read, registered on the input transfer
  always_ff @(posedge clk) begin
    if (in_fire) begin
      curve_rd_r <= curve_mem[rd_addr[MEM_AW-1:0]];
    end
  end

  // Stage 1 register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_func_r  <= in_func;
      s1_fade_r  <= in_fade;
      s1_level_r <= in_level;
    end
  end

  // Eased step: base + trunc0(diff * curve / 2^16), saturated
  always_comb begin
    req_sat  = (s1_level_r > REQ_W'(MAX_LEVEL)) ? MAX_LEVEL : s1_level_r[LVL_W-1:0];
    if (down_r) begin
      diff = $signed({1'b0, start_r}) - $signed({1'b0, target_r});
      base = target_r;
    end else begin
      diff = $signed({1'b0, target_r}) - $signed({1'b0, start_r});
      base = start_r;
    end
    prod     = diff * curve_rd_r;
    prod_adj = prod + (prod[LVL_W+CRV_W] ? (LVL_W+CRV_W+1)'(2**FRAC_W - 1)
                                         : (LVL_W+CRV_W+1)'(0));
    ease     = prod_adj[LVL_W+CRV_W:FRAC_W];
    sum      = $signed({4'b0000, base}) + (LVL_W+4)'(ease);
    if (sum < 0) begin
      stepped = '0;
    end else if (sum > $signed({4'b0000, MAX_LEVEL})) begin
      stepped = MAX_LEVEL;
    end else begin
      stepped = sum[LVL_W-1:0];
    end
  end

  // Command decode and next fader state
  always_comb begin
    start_nxt   = start_r;
    target_nxt  = target_r;
    current_nxt = current_r;
    remem_nxt   = remem_r;
    down_nxt    = down_r;
    step_nxt    = step_r;
    written_nxt = 1'b0;
    if (s1_valid_r) begin
      case (s1_func_r)
        FUNC_SET: begin
          start_nxt  = current_r;
          target_nxt = req_sat;
          remem_nxt  = req_sat;
          if (s1_fade_r) begin
            if (req_sat < current_r) begin
              down_nxt = 1'b1;
              step_nxt = STEP_LAST;
            end else if (req_sat > current_r) begin
              down_nxt = 1'b0;
              step_nxt = '0;
            end
          end else begin
            current_nxt = req_sat;
            written_nxt = 1'b1;
          end
        end
        FUNC_ON: begin
          target_nxt = remem_r;
          if (s1_fade_r) begin
            start_nxt = current_r;
            if (remem_r < current_r) begin
              down_nxt = 1'b1;
              step_nxt = STEP_LAST;
            end else if (remem_r > current_r) begin
              down_nxt = 1'b0;
              step_nxt = '0;
            end
          end else begin
            current_nxt = remem_r;
            written_nxt = 1'b1;
          end
        end
        FUNC_OFF: begin
          start_nxt  = current_r;
          target_nxt = '0;
          if (s1_fade_r) begin
            down_nxt = 1'b1;
            step_nxt = STEP_LAST;
          end else begin
            current_nxt = '0;
            written_nxt = 1'b1;
          end
        end
        FUNC_TICK: begin
          if (current_r != target_r) begin
            written_nxt = 1'b1;
            if (down_r) begin
              step_nxt    = step_r - 1'b1;
              current_nxt = (step_nxt == '0) ? target_r : stepped;
            end else begin
              step_nxt    = step_r + 1'b1;
              current_nxt = (step_nxt == STEP_LAST) ? target_r : stepped;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Fader state registers, advanced as stage 1 retires
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r   <= '0;
      target_r  <= '0;
      current_r <= '0;
      remem_r   <= '0;
      down_r    <= 1'b0;
      step_r    <= '0;
    end else if (s1_fire) begin
      start_r   <= start_nxt;
      target_r  <= target_nxt;
      current_r <= current_nxt;
      remem_r   <= remem_nxt;
      down_r    <= down_nxt;
      step_r    <= step_nxt;
    end
  end

  // Output register: hold until the result transfer completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_level_r   <= current_nxt;
      out_written_r <= written_nxt;
      out_fading_r  <= (current_nxt != target_nxt);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_drive_level   = out_level_r;
  assign out_drive_written = out_written_r;
  assign out_fading        = out_fading_r;

`ifndef NO_ASSERTIONS
  // Step index stays on the curve
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= STEP_LAST)
    else $error("step index left the curve");

  // No new transfer while both stages are full and the output stalls
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && !out_ready |-> !in_ready)
    else $error("input taken while pipeline is blocked");

  // A stalled stage 1 item is kept
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_fire |=> s1_valid_r)
    else $error("stage 1 item dropped");

  // Reported level never exceeds the ceiling
  a_level_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_level_r <= MAX_LEVEL)
    else $error("drive level above maximum");
`endif

endmodule

`default_nettype wire

>>> dv/tb_eased_brightness_fader.sv
// ----------------------------------------------------------------------------
// tb_eased_brightness_fader
// Self-checking bench for the eased brightness fader. A behavioral copy of
// the fade engine predicts drive level, write flag and fading flag for every
// command transfer. A monitor compares each result transfer in order. Stimulus
// runs directed corner cases, an output stall that backs up the pipeline, and
// random fade episodes with random curves and random idle on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_eased_brightness_fader
  import ebf_pkg::*;
();

  localparam int CURVE_STEPS  = 41;
  localparam int PIPE_LAT     = 2;
  localparam int RANDOM_ITEMS = 850;
  localparam int DRAIN_LIMIT  = 2000;
  localparam int LAST_INDEX   = (1 << STEP_W) - 1;

  typedef enum {CURVE_EASE_IN, CURVE_LINEAR, CURVE_RANDOM, CURVE_OVERSHOOT} curve_shape_t;

  typedef struct packed {
    logic [LVL_W-1:0] level;
    logic             written;
    logic             fading;
  } drive_result_t;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_ready;
  logic [2:0]               in_func;
  logic                     in_fade;
  logic [REQ_W-1:0]         in_level;
  logic [STEP_W-1:0]        in_curve_index;
  logic signed [CRV_W-1:0]  in_curve_value;
  logic                     out_valid;
  logic                     out_ready;
  logic [LVL_W-1:0]         out_drive_level;
  logic                     out_drive_written;
  logic                     out_fading;

  // Fade engine shadow state
  logic [LVL_W-1:0]         lv_start;
  logic [LVL_W-1:0]         lv_target;
  logic [LVL_W-1:0]         lv_now;
  logic [LVL_W-1:0]         lv_saved;
  logic                     going_down;
  logic [STEP_W-1:0]        step_pos;
  logic signed [CRV_W-1:0]  curve_mem [1 << STEP_W];

  drive_result_t            drive_due_q[$];
  int                       mismatch_count = 0;
  int                       items_sent = 0;
  bit                       tx_nogap = 1'b0;
  bit                       rx_nogap = 1'b0;
  int                       rx_hold = 0;

  eased_brightness_fader #(
    .CURVE_STEPS(CURVE_STEPS)
  ) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_fade          (in_fade),
    .in_level         (in_level),
    .in_curve_index   (in_curve_index),
    .in_curve_value   (in_curve_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_drive_level  (out_drive_level),
    .out_drive_written(out_drive_written),
    .out_fading       (out_fading)
  );

  always #10 clk = ~clk;

  // Hard stop in case the handshake hangs
  initial begin
    #4_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Saturate a signed sum to the legal level range
  function automatic logic [LVL_W-1:0] sat_level(input longint v);
    if (v < 0) return '0;
    if (v > longint'(MAX_LEVEL)) return MAX_LEVEL;
    return LVL_W'(v);
  endfunction

  // Pick the fade direction from target vs current; equal leaves it alone
  task automatic pick_direction();
    if (lv_target < lv_now) begin
      going_down = 1'b1;
      step_pos   = STEP_W'(CURVE_STEPS - 1);
    end else if (lv_target > lv_now) begin
      going_down = 1'b0;
      step_pos   = '0;
    end
  endtask

  // Advance the shadow engine by one command and queue the expected result
  task automatic predict_drive(input logic [2:0] func, input logic fade,
                               input logic [REQ_W-1:0] req, input logic [STEP_W-1:0] cidx,
                               input logic signed [CRV_W-1:0] cval);
    drive_result_t    res;
    logic [LVL_W-1:0] lvl;
    logic             wr;
    longint           diff, base, ease, c;
    wr = 1'b0;
    case (func)
      FUNC_SET: begin
        lvl       = sat_level(longint'(req));
        lv_start  = lv_now;
        lv_target = lvl;
        lv_saved  = lvl;
        if (fade) begin
          pick_direction();
        end else begin
          lv_now = lvl;
          wr     = 1'b1;
        end
      end
      FUNC_ON: begin
        lv_target = lv_saved;
        if (fade) begin
          lv_start = lv_now;
          pick_direction();
        end else begin
          lv_now = lv_saved;
          wr     = 1'b1;
        end
      end
      FUNC_OFF: begin
        lv_start  = lv_now;
        lv_target = '0;
        if (fade) begin
          going_down = 1'b1;
          step_pos   = STEP_W'(CURVE_STEPS - 1);
        end else begin
          lv_now = '0;
          wr     = 1'b1;
        end
      end
      FUNC_TICK: begin
        if (lv_now != lv_target) begin
          c = longint'(curve_mem[step_pos]);
          if (going_down) begin
            diff     = longint'(lv_start) - longint'(lv_target);
            base     = longint'(lv_target);
            step_pos = step_pos - 1'b1;
            ease     = (diff * c) / 65536;
            lv_now   = (step_pos == '0) ? lv_target : sat_level(base + ease);
          end else begin
            diff     = longint'(lv_target) - longint'(lv_start);
            base     = longint'(lv_start);
            step_pos = step_pos + 1'b1;
            ease     = (diff * c) / 65536;
            lv_now   = (step_pos == STEP_W'(CURVE_STEPS - 1)) ? lv_target
                                                              : sat_level(base + ease);
          end
          wr = 1'b1;
        end
      end
      FUNC_LOAD: begin
        if (cidx < CURVE_STEPS) curve_mem[cidx] = cval;
      end
      default: ;
    endcase
    res.level   = lv_now;
    res.written = wr;
    res.fading  = (lv_now != lv_target);
    drive_due_q.push_back(res);
  endtask

  // Offer one command after a random idle gap and hold it until the transfer
  task automatic send_cmd(input logic [2:0] func, input logic fade,
                          input logic [REQ_W-1:0] req, input logic [STEP_W-1:0] cidx,
                          input logic signed [CRV_W-1:0] cval);
    int gap;
    gap = tx_nogap ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_func        <= func;
    in_fade        <= fade;
    in_level       <= req;
    in_curve_index <= cidx;
    in_curve_value <= cval;
    do @(posedge clk); while (!in_ready);
    predict_drive(func, fade, req, cidx, cval);
    items_sent++;
  endtask

  function automatic logic signed [CRV_W-1:0] rand_curve_value();
    int v;
    v = int'($urandom_range(0, 131072)) - 32768;
    return CRV_W'(v);
  endfunction

  function automatic logic [REQ_W-1:0] rand_level();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return REQ_W'(MAX_LEVEL);
      2, 3:    return REQ_W'($urandom_range(int'(MAX_LEVEL) + 1, (1 << REQ_W) - 1));
      default: return REQ_W'($urandom_range(0, int'(MAX_LEVEL)));
    endcase
  endfunction

  // Level commands carry random curve fields
  task automatic send_level(input logic [2:0] func, input logic fade,
                            input logic [REQ_W-1:0] req);
    send_cmd(func, fade, req, STEP_W'($urandom_range(0, LAST_INDEX)), rand_curve_value());
  endtask

  // Ticks carry random payload in every field
  task automatic send_tick();
    send_cmd(FUNC_TICK, 1'($urandom_range(0, 1)), REQ_W'($urandom_range(0, 4095)),
             STEP_W'($urandom_range(0, LAST_INDEX)), rand_curve_value());
  endtask

  task automatic send_load(input logic [STEP_W-1:0] cidx, input logic signed [CRV_W-1:0] cval);
    send_cmd(FUNC_LOAD, 1'($urandom_range(0, 1)), REQ_W'($urandom_range(0, 4095)), cidx, cval);
  endtask

  // Write every curve entry with the given profile
  task automatic load_curve(input curve_shape_t shape);
    int span, v;
    span = CURVE_STEPS - 1;
    for (int i = 0; i < CURVE_STEPS; i++) begin
      case (shape)
        CURVE_EASE_IN: v = (i * i * 65536) / (span * span);
        CURVE_LINEAR:  v = (i * 65536) / span;
        CURVE_RANDOM:  v = int'(rand_curve_value());
        default:       v = (i * 65536) / span + (i * (span - i) * 131072) / (span * span);
      endcase
      send_load(STEP_W'(i), CRV_W'(v));
    end
  endtask

  // Idle tick, unused command codes and out-of-range curve writes
  task automatic test_idle_and_unused();
    send_tick();
    for (int f = int'(FUNC_LOAD) + 1; f < (1 << 3); f++) begin
      send_level(3'(f), 1'b1, REQ_W'($urandom_range(0, 4095)));
    end
    send_load(STEP_W'(CURVE_STEPS), CRV_W'(98304));
    send_load(STEP_W'(LAST_INDEX), CRV_W'(-32768));
  endtask

  // Fill the curve before any fade; plant both value extremes
  task automatic test_curve_load();
    load_curve(CURVE_EASE_IN);
    send_load(STEP_W'(1), CRV_W'(-32768));
    send_load(STEP_W'(CURVE_STEPS / 2), CRV_W'(98304));
  endtask

  // Immediate level changes, including saturation of the request
  task automatic test_jumps();
    send_level(FUNC_SET, 1'b0, REQ_W'((1 << REQ_W) - 1));
    send_level(FUNC_SET, 1'b0, '0);
    send_level(FUNC_SET, 1'b0, REQ_W'(MAX_LEVEL));
    send_level(FUNC_OFF, 1'b0, '0);
    send_level(FUNC_ON, 1'b0, '0);
  endtask

  // Short fades: interrupted fades, equal-level fade, on/off fades
  task automatic test_directed_fades();
    send_level(FUNC_OFF, 1'b0, '0);
    send_level(FUNC_SET, 1'b1, REQ_W'((1 << REQ_W) - 1));
    repeat (3) send_tick();
    send_level(FUNC_SET, 1'b1, REQ_W'(lv_now));
    send_tick();
    send_level(FUNC_OFF, 1'b1, '0);
    repeat (2) send_tick();
    send_level(FUNC_ON, 1'b1, '0);
    repeat (2) send_tick();
    send_level(FUNC_SET, 1'b1, REQ_W'(100));
    send_tick();
  endtask

  // Hold the output long enough that the input stalls
  task automatic test_backpressure();
    tx_nogap = 1'b1;
    rx_hold  = 60;
    send_level(FUNC_SET, 1'b1, rand_level());
    repeat (30) send_tick();
    tx_nogap = 1'b0;
  endtask

  // Mostly full fade episodes, plus jumps, curve rewrites and noise
  task automatic test_random_traffic();
    ebf_func_t fade_ops [4] = '{FUNC_SET, FUNC_SET, FUNC_ON, FUNC_OFF};
    ebf_func_t jump_ops [3] = '{FUNC_SET, FUNC_ON, FUNC_OFF};
    int        start_count, pick, n_ticks;
    start_count = items_sent;
    while (items_sent - start_count < RANDOM_ITEMS) begin
      tx_nogap = ($urandom_range(0, 3) == 0);
      rx_nogap = ($urandom_range(0, 3) == 0);
      pick     = $urandom_range(0, 99);
      if (pick < 70) begin
        send_level(fade_ops[$urandom_range(0, 3)], 1'b1, rand_level());
        n_ticks = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 20) : $urandom_range(38, 45);
        repeat (n_ticks) send_tick();
      end else if (pick < 85) begin
        send_level(jump_ops[$urandom_range(0, 2)], 1'b0, rand_level());
        repeat ($urandom_range(0, 3)) send_tick();
      end else if (pick < 90) begin
        send_load(STEP_W'($urandom_range(0, CURVE_STEPS - 1)), rand_curve_value());
      end else if (pick < 92) begin
        load_curve(curve_shape_t'($urandom_range(0, 3)));
      end else begin
        case ($urandom_range(0, 2))
          0: send_level(3'(int'(FUNC_LOAD) + $urandom_range(1, 3)), 1'($urandom_range(0, 1)),
                        REQ_W'($urandom_range(0, 4095)));
          1: send_load(STEP_W'($urandom_range(CURVE_STEPS, LAST_INDEX)), rand_curve_value());
          default: send_tick();
        endcase
      end
    end
    tx_nogap = 1'b0;
    rx_nogap = 1'b0;
  endtask

  // Release the input and wait for outstanding results
  task automatic drain_results();
    int waited;
    in_valid <= 1'b0;
    waited = 0;
    while (drive_due_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (PIPE_LAT * 4) @(posedge clk);
    if (drive_due_q.size() != 0) begin
      $error("%0d results never arrived", drive_due_q.size());
      mismatch_count++;
    end
  endtask

  // Stimulus sequence
  initial begin
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_func        <= FUNC_TICK;
    in_fade        <= 1'b0;
    in_level       <= '0;
    in_curve_index <= '0;
    in_curve_value <= '0;
    lv_start   = '0;
    lv_target  = '0;
    lv_now     = '0;
    lv_saved   = '0;
    going_down = 1'b0;
    step_pos   = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_idle_and_unused();
    test_curve_load();
    test_jumps();
    test_directed_fades();
    test_backpressure();
    test_random_traffic();
    drain_results();
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Result side: random stalls, one long hold on request, in-order compare
  initial begin : drive_monitor
    drive_result_t want;
    int            stall;
    out_ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (rx_hold > 0) begin
        stall   = rx_hold;
        rx_hold = 0;
      end else begin
        stall = rx_nogap ? 0 : $urandom_range(0, 5);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (drive_due_q.size() == 0) begin
        $error("result with nothing pending: drive_level %0d", out_drive_level);
        mismatch_count++;
      end else begin
        want = drive_due_q.pop_front();
        if (out_drive_level !== want.level) begin
          $error("drive_level: expected %0d, got %0d", want.level, out_drive_level);
          mismatch_count++;
        end
        if (out_drive_written !== want.written) begin
          $error("drive_written: expected %0d, got %0d", want.written, out_drive_written);
          mismatch_count++;
        end
        if (out_fading !== want.fading) begin
          $error("fading: expected %0d, got %0d", want.fading, out_fading);
          mismatch_count++;
        end
      end
    end
  end

endmodule

>>> files.f
sv/ebf_pkg.sv
sv/eased_brightness_fader.sv
dv/tb_eased_brightness_fader.sv
